/* design/sxc_pkg.sv */
// Shared types, constants and round functions for the SHA-1 chained XOR cipher.
// Used by sxc_ctrl, sxc_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package sxc_pkg;

  typedef logic [31:0] word_t;

  localparam int BLOCK_W   = 160;
  localparam int SEED_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ROUNDS    = 80;
  localparam int RND_W     = 7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd3;

  // Round groups of the compression function
  typedef enum logic [1:0] {
    PH_CHOOSE = 2'd0,
    PH_PARITY1 = 2'd1,
    PH_MAJORITY = 2'd2,
    PH_PARITY2 = 2'd3
  } phase_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t PAD_WORD = 32'h80000000;
  localparam word_t LEN_WORD = 32'd160;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic   load;    // accept a block: transform it and seed the hash
    logic   round;   // run one compression round
    logic   finish;  // fold the working words into the chain value
    phase_t phase;
  } cmd_t;

  function automatic word_t sha1_f(phase_t ph, word_t b, word_t c, word_t d);
    word_t f;
    case (ph)
      PH_CHOOSE:   f = (b & c) | (~b & d);
      PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
      default:     f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t sha1_k(phase_t ph);
    word_t k;
    case (ph)
      PH_CHOOSE:   k = 32'h5A827999;
      PH_PARITY1:  k = 32'h6ED9EBA1;
      PH_MAJORITY: k = 32'h8F1BBCDC;
      default:     k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

/* design/sxc_ctrl.sv */
// Controller of the SHA-1 chained XOR cipher: handshakes, round counter and commands.
// Depends on sxc_pkg.
`timescale 1ns / 1ps

module sxc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output sxc_pkg::cmd_t cmd
);
  import sxc_pkg::*;

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             ovld_r, ovld_nxt;
  logic             accept;

  assign in_tready  = (state_r == S_IDLE) && (!ovld_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_ROUND;
          rnd_nxt   = '0;
        end
      end
      S_ROUND: begin
        rnd_nxt = rnd_r + RND_W'(1);
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register: fill on accept, drop once the transfer completes
  always_comb begin
    ovld_nxt = ovld_r;
    if (accept) begin
      ovld_nxt = 1'b1;
    end else if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd.load   = accept;
    cmd.round  = (state_r == S_ROUND);
    cmd.finish = (state_r == S_FINAL);
    if (rnd_r < RND_W'(20)) begin
      cmd.phase = PH_CHOOSE;
    end else if (rnd_r < RND_W'(40)) begin
      cmd.phase = PH_PARITY1;
    end else if (rnd_r < RND_W'(60)) begin
      cmd.phase = PH_MAJORITY;
    end else begin
      cmd.phase = PH_PARITY2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

/* design/sxc_datapath.sv */
// Datapath of the SHA-1 chained XOR cipher: key registers, chain value, result
// register and one SHA-1 round unit with its message schedule. Depends on sxc_pkg.
`timescale 1ns / 1ps

module sxc_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sxc_pkg::cmd_t                  cmd,
  input  logic                           cfg_we,
  input  logic [sxc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sxc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           first_block,
  input  logic [sxc_pkg::BLOCK_W-1:0]    blk_data,
  output logic [sxc_pkg::BLOCK_W-1:0]    res_data
);
  import sxc_pkg::*;

  logic [SEED_W-1:0] seed_high_r, seed_mid_r;
  word_t             seed_low_r;
  logic              dir_r;
  word_t             chain_r [5];
  logic              started_r;
  word_t             a_r, b_r, c_r, d_r, e_r;
  word_t             w_r [16];
  logic [BLOCK_W-1:0] res_r;

  word_t blk [5];
  word_t chain_eff [5];
  word_t res_w [5];
  word_t msg [5];
  word_t t_sum, w_new;
  logic  reload;

  // Word 0 is block bytes 0..3
  assign blk[0] = blk_data[63:32];
  assign blk[1] = blk_data[31:0];
  assign blk[2] = blk_data[127:96];
  assign blk[3] = blk_data[95:64];
  assign blk[4] = blk_data[159:128];

  assign reload = first_block || !started_r;

  always_comb begin
    if (reload) begin
      chain_eff[0] = ~seed_high_r[63:32];
      chain_eff[1] = ~seed_high_r[31:0];
      chain_eff[2] = ~seed_mid_r[63:32];
      chain_eff[3] = ~seed_mid_r[31:0];
      chain_eff[4] = ~seed_low_r;
    end else begin
      for (int i = 0; i < 5; i++) chain_eff[i] = chain_r[i];
    end
    for (int i = 0; i < 5; i++) begin
      res_w[i] = blk[i] ^ chain_eff[i];
      msg[i]   = dir_r ? res_w[i] : blk[i];
    end
  end

  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1_f(cmd.phase, b_r, c_r, d_r) + e_r
               + sha1_k(cmd.phase) + w_r[0];
  assign w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_high_r <= '0;
      seed_mid_r  <= '0;
      seed_low_r  <= '0;
      dir_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED_HIGH: seed_high_r <= cfg_data;
        REG_SEED_MID:  seed_mid_r  <= cfg_data;
        REG_SEED_LOW:  seed_low_r  <= cfg_data[31:0];
        REG_DIRECTION: dir_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      for (int i = 0; i < 5; i++) chain_r[i] <= '0;
    end else if (cmd.load) begin
      started_r <= 1'b1;
      for (int i = 0; i < 5; i++) chain_r[i] <= chain_eff[i];
    end else if (cmd.finish) begin
      chain_r[0] <= IV0 + a_r;
      chain_r[1] <= IV1 + b_r;
      chain_r[2] <= IV2 + c_r;
      chain_r[3] <= IV3 + d_r;
      chain_r[4] <= IV4 + e_r;
    end
  end

  // Working words and message window; window slot 0 holds the current round word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= {res_w[4], res_w[2], res_w[3], res_w[0], res_w[1]};
      a_r <= IV0;
      b_r <= IV1;
      c_r <= IV2;
      d_r <= IV3;
      e_r <= IV4;
      for (int i = 0; i < 5; i++) w_r[i] <= msg[i];
      w_r[5] <= PAD_WORD;
      for (int i = 6; i < 15; i++) w_r[i] <= '0;
      w_r[15] <= LEN_WORD;
    end else if (cmd.round) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= {w_new[30:0], w_new[31]};
    end
  end

  assign res_data = res_r;

endmodule

/* design/sha1_chained_xor_cipher.sv */
// Top level of the SHA-1 chained XOR cipher: joins controller and datapath.
// Depends on sxc_pkg, sxc_ctrl and sxc_datapath.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------------
//   in_     | in  | in_tvalid/in_tready | in_tdata 160b block, in_tuser first_block
//   out_    | out | out_tvalid/tready   | out_tdata 160b transformed block
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// A block passes through the accept cycle, 80 rounds of the single shared
// SHA-1 round unit, and a final step that folds the digest into the chain value.
// The result is ready in the cycle after the transfer, while the hash runs on.
// The next block is taken once the digest is folded in and the result register
// is empty or being drained. Reset (rst_n, synchronous, active low) clears the
// keys, direction and chain state. Configuration writes are always taken.
`timescale 1ns / 1ps

module sha1_chained_xor_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [63:0] data_high, [127:64] data_mid, [159:128] data_low
  input  logic [sxc_pkg::BLOCK_W-1:0]    in_tdata,
  // [0] first_block
  input  logic                           in_tuser,
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [63:0] result_high, [127:64] result_mid, [159:128] result_low
  output logic [sxc_pkg::BLOCK_W-1:0]    out_tdata,
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sxc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sxc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sxc_pkg::*;

  cmd_t cmd;

  // Register file never stalls a write
  assign cfg_ready = 1'b1;

  sxc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Transform on accept, then hash the ciphertext side to advance the chain
  sxc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .first_block (in_tuser),
    .blk_data    (in_tdata),
    .res_data    (out_tdata)
  );

endmodule

/* design/sxc_checker.sv */
// Port-level checks for the SHA-1 chained XOR cipher, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module sxc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  // Hold off the next block while the current hash runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken during hash");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##81 !in_tready)
    else $error("input taken before digest folded in");

  // A result only appears right after a block transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without block");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind sha1_chained_xor_cipher sxc_checker u_sxc_checker (.*);

/* tb/tb.sv */
// Self-checking bench for sha1_chained_xor_cipher: directed and random blocks,
// predicted by a local SHA-1 chain model. Depends on sxc_pkg and the design.
`timescale 1ns / 1ps

module tb;
  import sxc_pkg::*;

  localparam int HASH_SETTLE = 90;    // one full compression plus margin
  localparam int STALL_LIMIT = 3000;  // cycles without any transfer
  localparam int HOLDOFF_LEN = 600;   // long receiver stall
  localparam int RANDOM_ITEMS = 207;  // per idling mode

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] K_PARITY1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] K_PARITY2  = 32'hCA62C1D6;

  localparam logic [63:0] ONES64 = {64{1'b1}};
  localparam logic [31:0] ONES32 = {32{1'b1}};
  localparam logic [63:0] ALT_A  = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT_5  = 64'h5555_5555_5555_5555;

  // One 20-byte block, bytes 0..3 in the top word
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] mid;
    logic [31:0] low;
  } cipher_block_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [63:0] data_high, [127:64] data_mid, [159:128] data_low
  logic [BLOCK_W-1:0]    in_tdata = '0;
  // [0] first_block
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [63:0] result_high, [127:64] result_mid, [159:128] result_low
  logic [BLOCK_W-1:0]    out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the cipher's registers and chain
  logic [159:0] seed_key = '0;
  logic         encrypt_mode = 1'b0;
  logic [159:0] chain_words = '0;
  logic         chain_live = 1'b0;

  cipher_block_t pending_blocks[$];
  int fail_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int held_cycles = 0;     // advanced by the receiver only
  int holdoff_until = 0;   // raised by a test to request a stall
  int quiet_cycles = 0;

  sha1_chained_xor_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // SHA-1 of a single 20-byte message, padded to one 64-byte block
  function automatic logic [159:0] sha1_of_block(input logic [159:0] msg);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wi;
    int i;
    for (i = 0; i < 16; i++) w[i] = '0;
    for (i = 0; i < 5; i++) w[i] = msg[159 - 32 * i -: 32];
    w[5] = 32'h8000_0000;     // terminating one bit
    w[15] = 32'd160;          // message length in bits
    a = H0; b = H1; c = H2; d = H3; e = H4;
    for (i = 0; i < 80; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        wi = w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16];
        wi = {wi[30:0], wi[31]};
        w[i % 16] = wi;
      end
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = K_PARITY2;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wi;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    return {H0 + a, H1 + b, H2 + c, H3 + d, H4 + e};
  endfunction

  // XOR the block with the chain, queue the result, then rechain from the
  // ciphertext side: the input when decrypting, the result when encrypting
  task automatic xor_and_rechain(input logic first, input logic [159:0] blk);
    logic [159:0] res;
    if (first || !chain_live) begin
      chain_words = ~seed_key;
      chain_live = 1'b1;
    end
    res = blk ^ chain_words;
    chain_words = sha1_of_block(encrypt_mode ? res : blk);
    pending_blocks.push_back(res);
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ONES64;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ONES32;
      default: return $urandom;
    endcase
  endfunction

  // Offer one block after an optional sender gap; keep tvalid high on return
  task automatic send_block(input logic first, input logic [63:0] hi, mid,
                            input logic [31:0] lo);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 120) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lo, mid, hi};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    xor_and_rechain(first, {hi, mid, lo});
  endtask

  // Leave cfg_valid high on return: the caller drops it after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEED_HIGH: seed_key[159:96] = value;
      REG_SEED_MID:  seed_key[95:32]  = value;
      REG_SEED_LOW:  seed_key[31:0]   = value[31:0];
      REG_DIRECTION: encrypt_mode     = value[0];
      default: ;
    endcase
  endtask

  // Load seed and direction; upper junk bits must be masked by the block
  task automatic program_cipher(input logic [63:0] hi, mid, input logic [31:0] lo,
                                input logic dir);
    write_reg(REG_SEED_HIGH, hi);
    write_reg(REG_SEED_MID, mid);
    write_reg(REG_SEED_LOW, {$urandom, lo});
    write_reg(REG_DIRECTION, {$urandom, 31'($urandom), dir});
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, collect every result and let the running hash finish
  task automatic settle_cipher();
    in_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (HASH_SETTLE) @(posedge clk);
  endtask

  // First block after reset loads the inverted reset seed, flag or not
  task automatic test_reset_load();
    send_block(1'b0, '0, '0, '0);
    send_block(1'b0, ONES64, ONES64, ONES32);
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
  endtask

  task automatic test_field_extremes();
    program_cipher(ONES64, ONES64, ONES32, 1'b0);
    send_block(1'b1, ONES64, ONES64, ONES32);
    send_block(1'b0, '0, '0, '0);
    send_block(1'b1, ALT_A, ALT_5, ALT_A[31:0]);
    send_block(1'b0, ALT_5, ALT_A, ALT_5[31:0]);
    settle_cipher();
    program_cipher('0, '0, ONES32, 1'b1);
    send_block(1'b1, ONES64, ONES64, ONES32);
    send_block(1'b0, '0, '0, '0);
    settle_cipher();
  endtask

  // Writes to unused indexes must leave seed and direction alone
  task automatic test_ignored_indexes();
    program_cipher(pick64(), pick64(), pick32(), 1'b1);
    for (int i = REG_DIRECTION + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), ONES64);
    cfg_valid <= 1'b0;
    send_block(1'b1, pick64(), pick64(), pick32());
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
  endtask

  // A new seed waits for the next reload; the running chain carries on
  task automatic test_seed_midrun();
    program_cipher({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b0);
    send_block(1'b1, pick64(), pick64(), pick32());
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
    write_reg(REG_SEED_HIGH, {$urandom, $urandom});
    write_reg(REG_SEED_MID, {$urandom, $urandom});
    write_reg(REG_SEED_LOW, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_block(1'b0, pick64(), pick64(), pick32());
    send_block(1'b1, pick64(), pick64(), pick32());
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
  endtask

  // Flip direction between blocks of one chain, both ways
  task automatic test_direction_switch();
    program_cipher(pick64(), pick64(), pick32(), 1'b1);
    send_block(1'b1, pick64(), pick64(), pick32());
    send_block(1'b0, pick64(), pick64(), pick32());
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
    write_reg(REG_DIRECTION, '0);
    cfg_valid <= 1'b0;
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
    write_reg(REG_DIRECTION, 64'd1);
    cfg_valid <= 1'b0;
    send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
  endtask

  // Mostly well-formed runs that open with first_block set; a few runs
  // continue the old chain, and now and then a reload lands mid-run
  task automatic test_random_runs(input int tx_pct, input int rx_pct);
    int sent;
    int run_len;
    logic first;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        settle_cipher();
        program_cipher(pick64(), pick64(), pick32(), 1'($urandom_range(1)));
      end
      run_len = $urandom_range(1, 10);
      for (int j = 0; j < run_len; j++) begin
        if (j == 0) first = ($urandom_range(7) != 0);
        else        first = ($urandom_range(15) == 0);
        send_block(first, pick64(), pick64(), pick32());
        sent++;
      end
    end
    settle_cipher();
  endtask

  // Hold the result side off for a long stretch while blocks keep coming
  task automatic test_result_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holdoff_until = held_cycles + HOLDOFF_LEN;
    send_block(1'b1, pick64(), pick64(), pick32());
    for (int j = 0; j < 7; j++)
      send_block(1'b0, pick64(), pick64(), pick32());
    settle_cipher();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (held_cycles < holdoff_until) begin
      out_tready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    cipher_block_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        $error("result with none pending: out_tdata %h", out_tdata);
        fail_count++;
      end else begin
        due = pending_blocks.pop_front();
        if (out_tdata[63:0] !== due.high) begin
          $error("result_high: expected %h, actual %h", due.high, out_tdata[63:0]);
          fail_count++;
        end
        if (out_tdata[127:64] !== due.mid) begin
          $error("result_mid: expected %h, actual %h", due.mid, out_tdata[127:64]);
          fail_count++;
        end
        if (out_tdata[159:128] !== due.low) begin
          $error("result_low: expected %h, actual %h", due.low, out_tdata[159:128]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_load();
    test_field_extremes();
    test_ignored_indexes();
    test_seed_midrun();
    test_direction_switch();
    test_result_backpressure();
    test_random_runs(27, 61);
    test_random_runs(61, 27);
    test_random_runs(0, 0);
    settle_cipher();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
